/* hdl/bbi_pkg.sv */
// Shared types and constants for the 3x3 interior box blur core.
// Holds the channel payload structs, register index codes and divide-by-9 constants.
// No dependencies; used by the core, the result queue and the checker.
`timescale 1ns / 1ps

package bbi_pkg;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] IMAGE_WIDTH_RESET  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] IMAGE_HEIGHT_RESET = 11'd480;

    // Pixel and result geometry
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 3;
    localparam int PIX_W       = CHAN_W * NUM_CHAN;
    localparam int OUT_COORD_W = 10;

    // Sum of three channel values, sum of nine channel values
    localparam int COL_SUM_W = 10;
    localparam int SUM_W     = 12;

    // floor(x / 9) == (x * 3641) >> 15 for every x below 2^12
    localparam int DIV9_MULT  = 3641;
    localparam int DIV9_SHIFT = 15;
    localparam int PROD_W     = 24;

    // Result queue, depth must be a power of two
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_in_t;

    typedef struct packed {
        logic [OUT_COORD_W-1:0] pixel_row;
        logic [OUT_COORD_W-1:0] pixel_col;
        logic [CHAN_W-1:0]      out_red;
        logic [CHAN_W-1:0]      out_green;
        logic [CHAN_W-1:0]      out_blue;
        logic                   last_of_run;
    } pixel_out_t;

    typedef logic [NUM_CHAN-1:0][COL_SUM_W-1:0] col_sum_t;
    typedef logic [NUM_CHAN-1:0][SUM_W-1:0]     win_sum_t;

    // One or two results handed to the result queue in one cycle
    typedef struct packed {
        logic       en;
        logic       two;
        pixel_out_t first;
        pixel_out_t second;
    } bbi_push_t;

endpackage

/* hdl/box_blur_3x3_interior_core.sv */
// Top level of the 3x3 interior box blur: counters, line buffer, window and result stages.
// Depends on bbi_pkg, bbi_ram and bbi_result_queue.
`timescale 1ns / 1ps

// Usage
//   cfg channel : write image_width (index REG_IMAGE_WIDTH) or image_height
//                 (index REG_IMAGE_HEIGHT) while the core is idle. A write to either
//                 register restarts the frame at row 0, column 0; other indexes are
//                 dropped. cfg_ready is always high.
//   pix channel : one RGB pixel per transaction, raster order, up to one per clock.
//   res channel : per input pixel, zero, one or two result transactions. A border pixel
//                 comes back unchanged; an interior pixel comes back blurred when the
//                 pixel below-right of it arrives, ahead of that pixel's own border
//                 result. last_of_run marks the final result of an input pixel.
// Path: the line buffer read and the window sum of an accepted pixel are registered, the
//   divide-by-9 feeds the result queue, and the queue drives res_valid.
// Throughput: one pixel per clock while pixels cause at most one result each and res_ready
//   is high. A pixel with two results takes two output transactions; the four-entry result
//   queue absorbs the right-column pairs, but along the last row every pixel from column 2
//   on has two results, so there pix_ready drops whenever the result queue runs short of room.
// Stall: when res_ready stays low the queue fills, then pix_ready drops and the
//   pipeline holds its contents; nothing is lost.
// Reset: registers return to 640 x 480, counters to zero, pipeline and queue empty.
//   The line buffer RAM is not cleared; entries not yet written never feed a result.

module box_blur_3x3_interior_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bbi_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bbi_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              pix_valid,
    output logic                              pix_ready,
    input  bbi_pkg::pixel_in_t                pix_data,
    output logic                              res_valid,
    input  logic                              res_ready,
    output bbi_pkg::pixel_out_t               res_data
);

    import bbi_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    // Width for comparing against the effective dimensions
    localparam int EW = (CW + 1 > CFG_DATA_W) ? CW + 1 : CFG_DATA_W;
    localparam int HW = (RW + 1 > CFG_DATA_W) ? RW + 1 : CFG_DATA_W;
    localparam int LINE_W = 2 * PIX_W;

    // ---------------- configuration and position counters ----------------
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [CW-1:0]         col_reg;
    logic [CW-1:0]         col_next;
    logic [RW-1:0]         row_reg;
    logic [RW-1:0]         row_next;

    logic          cfg_fire;
    logic          cfg_known;
    logic          pix_fire;
    logic [EW-1:0] width_ext;
    logic [EW-1:0] width_eff;
    logic [HW-1:0] height_ext;
    logic [HW-1:0] height_eff;
    logic          col_last;
    logic          row_last;
    logic          inner_now;
    logic          border_now;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign cfg_known = (cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT);

    // A zero dimension acts as one; an oversized one saturates to the maximum.
    always_comb
    begin
        width_ext  = EW'(width_reg);
        height_ext = HW'(height_reg);
        if (width_reg == '0)
        begin
            width_eff = EW'(1);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            width_eff = EW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        if (height_reg == '0)
        begin
            height_eff = HW'(1);
        end
        else if (height_ext > HW'(MAX_HEIGHT))
        begin
            height_eff = HW'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = height_ext;
        end
    end

    // Counters always stay below the effective dimensions, so "+1 reaches the
    // dimension" is both the wrap test and the last-column/last-row border test.
    assign col_last   = (EW'(col_reg) + EW'(1) >= width_eff);
    assign row_last   = (HW'(row_reg) + HW'(1) >= height_eff);
    assign inner_now  = (row_reg >= RW'(2)) && (col_reg >= CW'(2));
    assign border_now = (row_reg == '0) || (col_reg == '0) || row_last || col_last;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_reg + RW'(1);
        end
        else
        begin
            col_next = col_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= IMAGE_WIDTH_RESET;
            height_reg <= IMAGE_HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else if (cfg_fire && cfg_known)
        begin
            // Restart the frame on any known register write.
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- pipeline control ----------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s1_adv;
    logic s2_adv;
    logic q_room;

    assign s2_adv    = s2_valid_reg && q_room;
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign pix_ready = !s1_valid_reg || s1_adv;
    assign pix_fire  = pix_valid & pix_ready;

    // ---------------- stage 1: line buffer read, column and window sums ----------------
    // The line buffer word holds {two rows up, one row up} for each column.
    logic [PIX_W-1:0]  s1_cur_reg;
    logic [CW-1:0]     s1_col_reg;
    logic [RW-1:0]     s1_row_reg;
    logic              s1_inner_reg;
    logic              s1_border_reg;
    logic              fwd_reg;
    logic [LINE_W-1:0] fwd_data_reg;

    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_word;
    logic [LINE_W-1:0] line_wr_data;
    logic [PIX_W-1:0]  two_up;
    logic [PIX_W-1:0]  one_up;
    col_sum_t          col_sum;
    col_sum_t          win_col0_reg;
    col_sum_t          win_col1_reg;
    win_sum_t          win_sum;

    bbi_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (line_wr_data),
        .rd_en   (pix_fire),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // A one-pixel-wide frame reads the column that the previous pixel writes in the
    // same cycle: take its write data instead of the stale RAM word.
    assign line_word    = fwd_reg ? fwd_data_reg : ram_rd_data;
    assign two_up       = line_word[LINE_W-1:PIX_W];
    assign one_up       = line_word[PIX_W-1:0];
    assign line_wr_data = {one_up, s1_cur_reg};

    // Keep per-column sums of the window; the 3x3 sum is three column sums.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            col_sum[ch] = COL_SUM_W'(two_up[ch*CHAN_W +: CHAN_W])
                        + COL_SUM_W'(one_up[ch*CHAN_W +: CHAN_W])
                        + COL_SUM_W'(s1_cur_reg[ch*CHAN_W +: CHAN_W]);
            win_sum[ch] = SUM_W'(win_col0_reg[ch]) + SUM_W'(win_col1_reg[ch])
                        + SUM_W'(col_sum[ch]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
            win_col0_reg <= '0;
            win_col1_reg <= '0;
        end
        else
        begin
            if (pix_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_adv && (s1_col_reg == col_reg);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            // Shift the window: oldest column out, current column in.
            if (s1_adv)
            begin
                win_col0_reg <= win_col1_reg;
                win_col1_reg <= col_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_cur_reg    <= pix_data;
            s1_col_reg    <= col_reg;
            s1_row_reg    <= row_reg;
            s1_inner_reg  <= inner_now;
            s1_border_reg <= border_now;
            fwd_data_reg  <= line_wr_data;
        end
    end

    // ---------------- stage 2: divide by 9, build results ----------------
    win_sum_t         s2_sum_reg;
    logic [PIX_W-1:0] s2_cur_reg;
    logic [CW-1:0]    s2_col_reg;
    logic [RW-1:0]    s2_row_reg;
    logic             s2_inner_reg;
    logic             s2_border_reg;

    logic [NUM_CHAN-1:0][PROD_W-1:0] prod;
    logic [NUM_CHAN-1:0][CHAN_W-1:0] quot;
    pixel_out_t inner_res;
    pixel_out_t border_res;
    bbi_push_t  push;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
        end
        else if (s2_adv)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_sum_reg    <= win_sum;
            s2_cur_reg    <= s1_cur_reg;
            s2_col_reg    <= s1_col_reg;
            s2_row_reg    <= s1_row_reg;
            s2_inner_reg  <= s1_inner_reg;
            s2_border_reg <= s1_border_reg;
        end
    end

    // Reciprocal multiply: exact truncated quotient for any sum of nine bytes.
    always_comb
    begin
        for (int ch = 0; ch < NUM_CHAN; ch++)
        begin
            prod[ch] = PROD_W'(s2_sum_reg[ch]) * PROD_W'(DIV9_MULT);
            quot[ch] = CHAN_W'(prod[ch] >> DIV9_SHIFT);
        end
    end

    always_comb
    begin
        // The finished interior pixel sits one row up and one column left.
        inner_res.pixel_row   = OUT_COORD_W'(s2_row_reg - RW'(1));
        inner_res.pixel_col   = OUT_COORD_W'(s2_col_reg - CW'(1));
        inner_res.out_red     = quot[2];
        inner_res.out_green   = quot[1];
        inner_res.out_blue    = quot[0];
        inner_res.last_of_run = !s2_border_reg;

        border_res.pixel_row   = OUT_COORD_W'(s2_row_reg);
        border_res.pixel_col   = OUT_COORD_W'(s2_col_reg);
        border_res.out_red     = s2_cur_reg[2*CHAN_W +: CHAN_W];
        border_res.out_green   = s2_cur_reg[CHAN_W +: CHAN_W];
        border_res.out_blue    = s2_cur_reg[0 +: CHAN_W];
        border_res.last_of_run = 1'b1;

        // Interior result first, then the pixel's own border result.
        push.en     = s2_adv && (s2_inner_reg || s2_border_reg);
        push.two    = s2_inner_reg && s2_border_reg;
        push.first  = s2_inner_reg ? inner_res : border_res;
        push.second = border_res;
    end

    // ---------------- result queue ----------------
    bbi_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (res_valid && res_ready),
        .room      (q_room),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

endmodule

/* hdl/bbi_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Parameterized by word width and depth; no package dependencies.
`timescale 1ns / 1ps

module bbi_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/bbi_result_queue.sv */
// Small result queue that takes one or two results per cycle and hands out one.
// Depends on bbi_pkg for the result struct, the push bundle and the queue depth.
`timescale 1ns / 1ps

module bbi_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  bbi_pkg::bbi_push_t push,
    input  logic               pop,
    output logic               room,
    output logic               out_valid,
    output bbi_pkg::pixel_out_t out_data
);

    import bbi_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pixel_out_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] push_n;

    always_comb
    begin
        if (!push.en)
        begin
            push_n = '0;
        end
        else if (push.two)
        begin
            push_n = CNT_W'(2);
        end
        else
        begin
            push_n = CNT_W'(1);
        end
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + push_n - (pop ? CNT_W'(1) : CNT_W'(0));
    end

    // Pushes never overrun: the producer checks room, which leaves space for two.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.en)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
            if (push.two)
            begin
                slot_reg[wr_ptr_reg + PTR_W'(1)] <= push.second;
            end
        end
    end

    assign room      = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];

endmodule

/* hdl/bbi_checker.sv */
// Port-level checker for box_blur_3x3_interior_core, attached by the bind below.
// Depends on bbi_pkg for the payload structs.
`timescale 1ns / 1ps

module bbi_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            pix_ready,
    input logic                            res_valid,
    input logic                            res_ready,
    input bbi_pkg::pixel_out_t             res_data
);

    // A stalled result transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed or dropped");

    // Nothing comes out while reset is asserted.
    assert property (@(posedge clk) !rst_n |-> !res_valid)
        else $error("result valid during reset");

    // With nothing waiting at the output the core must be ready for a new pixel.
    assert property (@(posedge clk) !res_valid |-> pix_ready)
        else $error("input blocked with an empty output");

    // A result that is not last of its run is a blurred interior pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last_of_run |->
            (res_data.pixel_row != 10'd0) && (res_data.pixel_col != 10'd0))
        else $error("non-final result outside the interior");

endmodule

bind box_blur_3x3_interior_core bbi_checker u_bbi_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_ready (pix_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
);
